>>> src/spec_pkg.sv
// Shared constants and item types for the sphere pair collision core.
`timescale 1ns / 1ps
package spec_pkg;

  localparam int FRAC_BITS = 16;
  localparam int CW = 31;
  localparam int QBITS = 34;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW = $clog2(FIFO_DEPTH);

  localparam logic [CW-1:0] CONTACT_RESET =
      CW'(((64'd21 << FRAC_BITS) + 64'd5) / 64'd10);

  // Item handed from the front part to the back part.
  typedef struct packed {
    logic [2:0][31:0]   va;
    logic [2:0][31:0]   vb;
    logic [2:0][CW-1:0] adp;
    logic [2:0]         dp_neg;
    logic               hit;
    logic [61:0]        d2;
    logic               dot_neg;
    logic [65:0]        dot_mag;
  } spec_item_t;

  // Side data that travels beside the dividers.
  typedef struct packed {
    logic             valid;
    logic [2:0][31:0] va;
    logic [2:0][31:0] vb;
    logic [2:0]       neg;
    logic             hit;
  } spec_meta_t;

  // Queue status seen by the top level.
  typedef struct packed {
    logic full;
    logic empty;
  } spec_fifo_stat_t;

endpackage

>>> src/spec_fifo.sv
// Short queue between the front part and the back part.
`timescale 1ns / 1ps
module spec_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  spec_pkg::spec_item_t wdata,
  input  logic                 pop,
  output spec_pkg::spec_item_t rdata,
  output spec_pkg::spec_fifo_stat_t stat
);
  import spec_pkg::*;

  spec_item_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr;
  logic [FIFO_AW-1:0]   rptr;
  logic [FIFO_AW:0]     count;
  logic                 do_push;
  logic                 do_pop;

  assign stat.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rdata      = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
    end
  end

endmodule

>>> src/spec_front.sv
// Front part: differences, contact test, products and the collision decision.
`timescale 1ns / 1ps
module spec_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 take,
  input  logic [spec_pkg::CW-1:0] contact,
  input  logic [2:0][31:0]     pa,
  input  logic [2:0][31:0]     va,
  input  logic [2:0][31:0]     pb,
  input  logic [2:0][31:0]     vb,
  output logic                 f_valid,
  output spec_pkg::spec_item_t f_item
);
  import spec_pkg::*;

  // Stage 1: differences.
  logic                   v1;
  logic [2:0][31:0]       va1, vb1;
  logic signed [32:0]     dp1 [3];
  logic signed [32:0]     dv1 [3];
  // Stage 2: magnitudes and the per-axis distance test.
  logic                   v2;
  logic [2:0][31:0]       va2, vb2;
  logic [32:0]            adp2 [3];
  logic [32:0]            adv2 [3];
  logic [2:0]             dpn2, pn2;
  logic                   near2;
  // Stage 3: products.
  logic                   v3;
  logic [2:0][31:0]       va3, vb3;
  logic [2:0][CW-1:0]     adp3;
  logic [2:0]             dpn3, pn3;
  logic                   near3;
  logic [61:0]            sq3 [3];
  logic [63:0]            pr3 [3];
  logic [61:0]            cc3;
  // Stage 4 combinational sums.
  logic [63:0]            d2_sum;
  logic signed [66:0]     dot_sum;
  logic                   near_c;

  always_comb begin
    near_c = (contact != '0);
    for (int i = 0; i < 3; i++) begin
      if (!(((dp1[i][32]) ? 33'(-dp1[i]) : 33'(dp1[i])) < {2'b00, contact})) begin
        near_c = 1'b0;
      end
    end
    d2_sum  = 64'(sq3[0]) + 64'(sq3[1]) + 64'(sq3[2]);
    dot_sum = '0;
    for (int i = 0; i < 3; i++) begin
      dot_sum = dot_sum + (pn3[i] ? -$signed({3'b000, pr3[i]})
                                  : $signed({3'b000, pr3[i]}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      f_valid <= 1'b0;
    end else if (en) begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
      f_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      va1 <= va;
      vb1 <= vb;
      for (int i = 0; i < 3; i++) begin
        dp1[i] <= $signed({pa[i][31], pa[i]}) - $signed({pb[i][31], pb[i]});
        dv1[i] <= $signed({va[i][31], va[i]}) - $signed({vb[i][31], vb[i]});
      end

      va2   <= va1;
      vb2   <= vb1;
      near2 <= near_c;
      for (int i = 0; i < 3; i++) begin
        adp2[i] <= dp1[i][32] ? 33'(-dp1[i]) : 33'(dp1[i]);
        adv2[i] <= dv1[i][32] ? 33'(-dv1[i]) : 33'(dv1[i]);
        dpn2[i] <= dp1[i][32];
        pn2[i]  <= dp1[i][32] ^ dv1[i][32];
      end

      va3   <= va2;
      vb3   <= vb2;
      dpn3  <= dpn2;
      pn3   <= pn2;
      near3 <= near2;
      cc3   <= 62'(contact) * 62'(contact);
      for (int i = 0; i < 3; i++) begin
        adp3[i] <= adp2[i][CW-1:0];
        sq3[i]  <= 62'(adp2[i][CW-1:0]) * 62'(adp2[i][CW-1:0]);
        pr3[i]  <= 64'(adv2[i]) * 64'(adp2[i][CW-1:0]);
      end

      f_item.va      <= va3;
      f_item.vb      <= vb3;
      f_item.adp     <= adp3;
      f_item.dp_neg  <= dpn3;
      f_item.hit     <= near3 && (d2_sum != '0) && (d2_sum < 64'(cc3));
      f_item.d2      <= d2_sum[61:0];
      f_item.dot_neg <= dot_sum[66];
      f_item.dot_mag <= dot_sum[66] ? 66'(-dot_sum) : 66'(dot_sum);
    end
  end

endmodule

>>> src/spec_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module spec_div (
  input  logic                     clk,
  input  logic                     en,
  input  logic [95:0]              num,
  input  logic [61:0]              den,
  output logic [spec_pkg::QBITS-1:0] quo
);
  import spec_pkg::*;

  logic [61:0]       r    [QBITS+1];
  logic [QBITS-1:0]  rest [QBITS+1];
  logic [QBITS-1:0]  q    [QBITS+1];
  logic [61:0]       d    [QBITS+1];
  logic [62:0]       t    [QBITS];
  logic              ge   [QBITS];
  logic [61:0]       nr   [QBITS];

  always_comb begin
    for (int k = 0; k < QBITS; k++) begin
      t[k]  = {r[k], rest[k][QBITS-1]};
      ge[k] = (t[k] >= {1'b0, d[k]});
      nr[k] = ge[k] ? 62'(t[k] - {1'b0, d[k]}) : t[k][61:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r[0]    <= num[95:QBITS];
      rest[0] <= num[QBITS-1:0];
      q[0]    <= '0;
      d[0]    <= den;
      for (int k = 0; k < QBITS; k++) begin
        r[k+1]    <= nr[k];
        rest[k+1] <= {rest[k][QBITS-2:0], 1'b0};
        q[k+1]    <= {q[k][QBITS-2:0], ge[k]};
        d[k+1]    <= d[k];
      end
    end
  end

  assign quo = q[QBITS];

endmodule

>>> src/spec_back.sv
// Back part: numerator products, three dividers and the saturated update.
`timescale 1ns / 1ps
module spec_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 b_take,
  input  spec_pkg::spec_item_t b_item,
  output logic                 o_valid,
  output logic [2:0][31:0]     o_a,
  output logic [2:0][31:0]     o_b,
  output logic                 o_hit
);
  import spec_pkg::*;

  // Stage 1: partial products of |dot| times |dp_i|.
  spec_meta_t       m1;
  logic [61:0]      d2_1;
  logic [63:0]      plo1 [3];
  logic [63:0]      phi1 [3];
  // Stage 2: full numerators.
  spec_meta_t       m2;
  logic [61:0]      d2_2;
  logic [95:0]      num2 [3];
  // Side data beside the divider stages.
  spec_meta_t       md [QBITS+1];
  logic [QBITS-1:0] quo [3];
  logic signed [35:0] sa [3];
  logic signed [35:0] sb [3];
  logic signed [35:0] sd [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      m1.valid <= 1'b0;
      m2.valid <= 1'b0;
      for (int k = 0; k <= QBITS; k++) begin
        md[k].valid <= 1'b0;
      end
      o_valid <= 1'b0;
    end else if (en) begin
      m1.valid <= b_take;
      m2.valid <= m1.valid;
      md[0].valid <= m2.valid;
      for (int k = 0; k < QBITS; k++) begin
        md[k+1].valid <= md[k].valid;
      end
      o_valid <= md[QBITS].valid;
    end

    if (en) begin
      m1.va  <= b_item.va;
      m1.vb  <= b_item.vb;
      m1.hit <= b_item.hit;
      d2_1   <= b_item.d2;
      for (int i = 0; i < 3; i++) begin
        m1.neg[i] <= b_item.dot_neg ^ b_item.dp_neg[i];
        plo1[i]   <= 64'(b_item.dot_mag[32:0]) * 64'(b_item.adp[i]);
        phi1[i]   <= 64'(b_item.dot_mag[65:33]) * 64'(b_item.adp[i]);
      end

      m2.va  <= m1.va;
      m2.vb  <= m1.vb;
      m2.neg <= m1.neg;
      m2.hit <= m1.hit;
      d2_2   <= d2_1;
      for (int i = 0; i < 3; i++) begin
        num2[i] <= 96'({phi1[i], 33'b0} + 97'(plo1[i]));
      end

      md[0].va  <= m2.va;
      md[0].vb  <= m2.vb;
      md[0].neg <= m2.neg;
      md[0].hit <= m2.hit;
      for (int k = 0; k < QBITS; k++) begin
        md[k+1].va  <= md[k].va;
        md[k+1].vb  <= md[k].vb;
        md[k+1].neg <= md[k].neg;
        md[k+1].hit <= md[k].hit;
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    spec_div u_div (
      .clk (clk),
      .en  (en),
      .num (num2[g]),
      .den (d2_2),
      .quo (quo[g])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sd[i] = md[QBITS].neg[i] ? -$signed({2'b00, quo[i]}) : $signed({2'b00, quo[i]});
      sa[i] = 36'(signed'(md[QBITS].va[i])) - sd[i];
      sb[i] = 36'(signed'(md[QBITS].vb[i])) + sd[i];
    end
  end

  function automatic logic [31:0] sat32(input logic signed [35:0] s);
    logic [31:0] r;
    if (s > 36'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (s < -36'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = s[31:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      o_hit <= md[QBITS].hit;
      for (int i = 0; i < 3; i++) begin
        o_a[i] <= md[QBITS].hit ? sat32(sa[i]) : md[QBITS].va[i];
        o_b[i] <= md[QBITS].hit ? sat32(sb[i]) : md[QBITS].vb[i];
      end
    end
  end

endmodule

>>> src/sphere_pair_elastic_collision_core.sv
// Top level of the equal-mass sphere pair elastic collision core.
`timescale 1ns / 1ps
// Each input item holds the positions and velocities of two equal-mass
// spheres in signed Q16.16. When the center distance is below the
// contact_distance register (and not zero) the velocities are exchanged
// along the line of centers: each changes by dot(dv,dp)*dp/|dp|^2, truncated
// toward zero, and the results saturate to 32 bits; collided is then 1.
// Otherwise both velocities pass through with collided 0. The block takes one
// item every cycle while neither side stalls. An item passes through the
// front part (differences, distance test, products, sums and compare), the
// queue, the numerator products, the pipelined restoring dividers (one
// quotient bit per stage) and the output register, in that order. The front
// part stalls the input only when the four-entry queue is full; the back
// part stalls only while a result waits at the output.
// The contact register is written through cfg_valid/cfg_ready/cfg_data and
// must only be written while the block holds no items.
module sphere_pair_elastic_collision_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [spec_pkg::CW-1:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] a_pos_x,
  input  logic [31:0] a_pos_y,
  input  logic [31:0] a_pos_z,
  input  logic [31:0] a_vel_x,
  input  logic [31:0] a_vel_y,
  input  logic [31:0] a_vel_z,
  input  logic [31:0] b_pos_x,
  input  logic [31:0] b_pos_y,
  input  logic [31:0] b_pos_z,
  input  logic [31:0] b_vel_x,
  input  logic [31:0] b_vel_y,
  input  logic [31:0] b_vel_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] a_new_vel_x,
  output logic [31:0] a_new_vel_y,
  output logic [31:0] a_new_vel_z,
  output logic [31:0] b_new_vel_x,
  output logic [31:0] b_new_vel_y,
  output logic [31:0] b_new_vel_z,
  output logic        collided
);
  import spec_pkg::*;

  logic [CW-1:0]    contact;
  logic             front_en;
  logic             front_valid;
  spec_item_t       front_item;
  spec_item_t       head_item;
  spec_fifo_stat_t  fstat;
  logic             back_en;
  logic             back_take;
  logic [2:0][31:0] new_a;
  logic [2:0][31:0] new_b;

  // The configuration register is always ready to take a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      contact <= CONTACT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      contact <= cfg_data;
    end
  end

  // The front pipeline advances unless its last stage holds an item that the
  // queue cannot take.
  assign front_en = !front_valid || !fstat.full;
  assign in_stall = !front_en;

  spec_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (front_en),
    .take    (in_valid && front_en),
    .contact (contact),
    .pa      ({a_pos_z, a_pos_y, a_pos_x}),
    .va      ({a_vel_z, a_vel_y, a_vel_x}),
    .pb      ({b_pos_z, b_pos_y, b_pos_x}),
    .vb      ({b_vel_z, b_vel_y, b_vel_x}),
    .f_valid (front_valid),
    .f_item  (front_item)
  );

  // The back pipeline moves whenever the output register is free or drains.
  assign back_en   = !out_valid || !out_stall;
  assign back_take = back_en && !fstat.empty;

  spec_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid && front_en),
    .wdata (front_item),
    .pop   (back_take),
    .rdata (head_item),
    .stat  (fstat)
  );

  spec_back u_back (
    .clk     (clk),
    .rst     (rst),
    .en      (back_en),
    .b_take  (back_take),
    .b_item  (head_item),
    .o_valid (out_valid),
    .o_a     (new_a),
    .o_b     (new_b),
    .o_hit   (collided)
  );

  assign a_new_vel_x = new_a[0];
  assign a_new_vel_y = new_a[1];
  assign a_new_vel_z = new_a[2];
  assign b_new_vel_x = new_b[0];
  assign b_new_vel_y = new_b[1];
  assign b_new_vel_z = new_b[2];

  // A finished item that is stalled stays at the output.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(collided))
    else $error("stalled result was lost or changed");

  // The queue never overflows: the front holds its item while the queue is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    front_valid && fstat.full |-> in_stall)
    else $error("front pushed into a full queue");

  // A register write lands in the next cycle.
  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |=> contact == $past(cfg_data))
    else $error("contact register write lost");

endmodule

>>> sim/tb_top.sv
// Self-checking testbench for the sphere pair elastic collision core.
`timescale 1ns / 1ps
module tb_top;
  import spec_pkg::*;

  // One sphere pair as it is sent, and the velocities expected back.
  typedef struct packed {
    logic [2:0][31:0] pa;
    logic [2:0][31:0] va;
    logic [2:0][31:0] pb;
    logic [2:0][31:0] vb;
  } pair_t;

  typedef struct packed {
    logic [2:0][31:0] na;
    logic [2:0][31:0] nb;
    logic             hit;
  } bounce_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  pair_t drv = '0;
  bounce_t got;

  logic [CW-1:0] contact = CONTACT_RESET;
  bounce_t bounce_q[$];
  int errors = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_cnt = 0;

  always #2 clk = ~clk;

  sphere_pair_elastic_collision_core dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .a_pos_x(drv.pa[0]), .a_pos_y(drv.pa[1]), .a_pos_z(drv.pa[2]),
    .a_vel_x(drv.va[0]), .a_vel_y(drv.va[1]), .a_vel_z(drv.va[2]),
    .b_pos_x(drv.pb[0]), .b_pos_y(drv.pb[1]), .b_pos_z(drv.pb[2]),
    .b_vel_x(drv.vb[0]), .b_vel_y(drv.vb[1]), .b_vel_z(drv.vb[2]),
    .out_valid(out_valid), .out_stall(out_stall),
    .a_new_vel_x(got.na[0]), .a_new_vel_y(got.na[1]), .a_new_vel_z(got.na[2]),
    .b_new_vel_x(got.nb[0]), .b_new_vel_y(got.nb[1]), .b_new_vel_z(got.nb[2]),
    .collided(got.hit)
  );

  function automatic logic [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7fffffff;
    if (v < -64'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction

  // Velocity exchange along the line of centers, exact integer arithmetic.
  function automatic bounce_t collide(pair_t p);
    logic signed [33:0] dp[3];
    logic signed [33:0] dv[3];
    logic [33:0] adp[3];
    logic [63:0] d2;
    logic signed [69:0] dot;
    logic [69:0] dmag;
    logic [127:0] num;
    logic [127:0] q;
    logic signed [63:0] dl;
    logic near;
    bounce_t r;
    near = (contact != 0);
    d2 = '0;
    dot = '0;
    for (int i = 0; i < 3; i++) begin
      dp[i] = $signed({{2{p.pa[i][31]}}, p.pa[i]}) - $signed({{2{p.pb[i][31]}}, p.pb[i]});
      dv[i] = $signed({{2{p.va[i][31]}}, p.va[i]}) - $signed({{2{p.vb[i][31]}}, p.vb[i]});
      adp[i] = dp[i] < 0 ? -dp[i] : dp[i];
      if (adp[i] >= 34'(contact)) near = 1'b0;
      r.na[i] = p.va[i];
      r.nb[i] = p.vb[i];
    end
    if (near)
      for (int i = 0; i < 3; i++) d2 += 64'(adp[i]) * 64'(adp[i]);
    r.hit = near && d2 != 0 && d2 < 64'(contact) * 64'(contact);
    if (r.hit) begin
      for (int i = 0; i < 3; i++) dot += 70'(dv[i]) * 70'(dp[i]);
      dmag = dot < 0 ? -dot : dot;
      for (int i = 0; i < 3; i++) begin
        num = 128'(dmag) * 128'(adp[i]);
        q = num / 128'(d2);
        // The quotient is capped far above anything that survives saturation.
        if (q > (128'd1 << 40)) q = 128'd1 << 40;
        dl = $signed(64'(q[40:0]));
        if ((dot < 0) != (dp[i] < 0)) dl = -dl;
        r.na[i] = clamp32($signed({{32{p.va[i][31]}}, p.va[i]}) - dl);
        r.nb[i] = clamp32($signed({{32{p.vb[i][31]}}, p.vb[i]}) + dl);
      end
    end
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps. It is entered
  // at a falling edge so that items inside a burst follow with no gap.
  task automatic send_pair(pair_t p);
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    drv = p;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    bounce_q.push_back(collide(p));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain();
    while (bounce_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_contact(logic [CW-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    contact = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      2: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      default: return $urandom_range(0, 1) ? 32'h7fffffff - $urandom_range(0, 15)
                                           : 32'h80000000 + $urandom_range(0, 15);
    endcase
  endfunction

  // Pair whose centers lie within roughly the contact distance.
  function automatic pair_t near_pair();
    pair_t p;
    int unsigned lim;
    lim = contact == 0 ? 1000 : contact;
    for (int i = 0; i < 3; i++) begin
      p.pa[i] = rnd_val();
      p.pb[i] = p.pa[i] + 32'($urandom_range(0, lim / 2)) - 32'($urandom_range(0, lim / 2));
      p.va[i] = rnd_val();
      p.vb[i] = rnd_val();
    end
    return p;
  endfunction

  task automatic test_extremes();
    pair_t p;
    p = {12{32'h7fffffff}};
    send_pair(p);
    p = {12{32'h80000000}};
    send_pair(p);
    p = '0;
    send_pair(p);
    // Coincident centers with moving spheres: no collision.
    p.va = {32'h0, 32'h0, 32'h00010000};
    p.vb = {32'h0, 32'h0, 32'hffff0000};
    send_pair(p);
    // Separation exactly equal to the contact distance is not a hit.
    p.pa[0] = 32'(contact);
    send_pair(p);
    // Just inside: head-on exchange.
    p.pa[0] = 32'(contact) - 1;
    send_pair(p);
    // Huge opposing velocities with a tiny offset drive saturation.
    p.pa = {32'h1, 32'h1, 32'h1};
    p.va = {32'h7fffffff, 32'h80000000, 32'h7fffffff};
    p.vb = {32'h80000000, 32'h7fffffff, 32'h80000000};
    send_pair(p);
    p.pb = {32'h80000000, 32'h7fffffff, 32'h0};
    send_pair(p);
    repeat (10) send_pair(near_pair());
  endtask

  task automatic test_random(int n);
    pair_t p;
    repeat (n) begin
      if ($urandom_range(0, 9) < 8) p = near_pair();
      else p = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                $urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
      send_pair(p);
    end
  endtask

  // Receiver stall pattern: off, random, or long stretches.
  always @(negedge clk) begin
    if (stall_cnt == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_cnt = $urandom_range(10, 200);
    end
    stall_cnt--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      default: out_stall <= ($urandom_range(0, 7) == 0) ? ~out_stall : out_stall;
    endcase
  end

  // Compare each accepted result with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (bounce_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
      end else begin
        bounce_t e;
        e = bounce_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (e.na[i] !== got.na[i]) begin
            errors++;
            $display("%0t: a_new_vel[%0d] expected %h got %h", $time, i, e.na[i], got.na[i]);
          end
          if (e.nb[i] !== got.nb[i]) begin
            errors++;
            $display("%0t: b_new_vel[%0d] expected %h got %h", $time, i, e.nb[i], got.nb[i]);
          end
        end
        if (e.hit !== got.hit) begin
          errors++;
          $display("%0t: collided expected %b got %b", $time, e.hit, got.hit);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_extremes();
    test_random(300);
    set_contact('0);
    test_extremes();
    test_random(150);
    set_contact({CW{1'b1}});
    test_extremes();
    test_random(400);
    set_contact(CW'(1));
    test_random(150);
    set_contact(CW'($urandom_range(1, 32'h7fffffff)));
    test_random(400);
    set_contact(CW'($urandom_range(1 << 12, 1 << 20)));
    test_extremes();
    test_random(400);
    drain();
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

>>> filelist.f
src/spec_pkg.sv
src/spec_fifo.sv
src/spec_front.sv
src/spec_div.sv
src/spec_back.sv
src/sphere_pair_elastic_collision_core.sv
sim/tb_top.sv
